// ===== rtl/core/stg_pkg.sv =====
package stg_pkg;

  localparam int PH_W  = 16;
  localparam int FC_W  = 24;
  localparam int CFG_W = 24;
  localparam int SMP_W = 16;
  localparam int QW    = 31;
  localparam int FB    = 30;
  localparam int NPOLY = 5;

  localparam int TONE_RESET = 440;
  localparam logic [SMP_W-1:0] MAG_MAX = 16'd32767;

  localparam logic [63:0] QONE  = 64'd1 << FB;
  localparam logic [63:0] DEC10 = 64'd10000000000;

  localparam logic [QW-1:0] C1  = QW'((64'd15707963268 * QONE) / DEC10);
  localparam logic [QW-1:0] C3  = QW'((64'd6459640975 * QONE) / DEC10);
  localparam logic [QW-1:0] C5  = QW'((64'd796926262 * QONE) / DEC10);
  localparam logic [QW-1:0] C7  = QW'((64'd46817541 * QONE) / DEC10);
  localparam logic [QW-1:0] C9  = QW'((64'd1604411 * QONE) / DEC10);
  localparam logic [QW-1:0] C11 = QW'((64'd35988 * QONE) / DEC10);

  localparam logic [QW-1:0] POLY_COEF [NPOLY] = '{C9, C7, C5, C3, C1};

  typedef enum logic [0:0] {
    REG_TONE_FREQ = 1'b0,
    REG_RUN_LEN   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic            last;
  } mid_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } out_item_t;

  function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] p;
    p = a * b;
    return p[QW+FB-1:FB];
  endfunction

endpackage

// ===== rtl/core/stg_fifo.sv =====
module stg_fifo #(
  parameter int WIDTH = 17,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] store_r [2**AW];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = cnt_r[AW];
  assign empty   = (cnt_r == '0);
  assign rdata   = store_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/stg_front.sv =====
module stg_front #(
  parameter int SAMPLE_RATE_HZ = 44100,
  parameter int INDEX_BITS     = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [stg_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      push,
  input  logic                      in_restart,
  output logic                      full,
  input  logic                      q_full,
  output logic                      q_push,
  output stg_pkg::mid_item_t        q_item
);

  localparam int PHW = stg_pkg::PH_W;
  localparam int PW1 = PHW + 1;
  localparam int FCW = stg_pkg::FC_W;
  localparam int LW  = (INDEX_BITS > FCW) ? INDEX_BITS : FCW;
  localparam logic [PW1-1:0] SR         = PW1'(SAMPLE_RATE_HZ);
  localparam logic [PHW-1:0] STEP_RESET = PHW'(stg_pkg::TONE_RESET % SAMPLE_RATE_HZ);

  logic [PHW-1:0]        step_r, step_nxt;
  logic                  red_r, red_nxt;
  logic [FCW-1:0]        fcnt_r, fcnt_nxt;
  logic [PHW-1:0]        phase_r, phase_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;

  logic                  acc, emit;
  logic [LW-1:0]         fc_ext;
  logic [INDEX_BITS-1:0] limit, idx_base, idx_inc;
  logic [PHW-1:0]        ph_base;
  logic [PW1-1:0]        ph_sum, ph_wrap;

  assign full     = q_full | red_r;
  assign acc      = push & ~full;
  assign fc_ext   = LW'(fcnt_r);
  assign limit    = fc_ext[INDEX_BITS-1:0];
  assign idx_base = in_restart ? '0 : idx_r;
  assign ph_base  = in_restart ? '0 : phase_r;
  assign idx_inc  = idx_base + 1'b1;
  assign emit     = acc & (idx_base < limit);
  assign ph_sum   = {1'b0, ph_base} + {1'b0, step_r};
  assign ph_wrap  = (ph_sum >= SR) ? ph_sum - SR : ph_sum;

  assign q_push       = emit;
  assign q_item.phase = ph_base;
  assign q_item.last  = (idx_inc == limit);

  // tone step is reduced modulo the sample rate by repeated subtraction
  always_comb begin
    step_nxt = step_r;
    red_nxt  = red_r;
    fcnt_nxt = fcnt_r;
    if (cfg_we) begin
      unique case (stg_pkg::cfg_reg_t'(cfg_index))
        stg_pkg::REG_TONE_FREQ: begin
          step_nxt = cfg_wdata[PHW-1:0];
          red_nxt  = 1'b1;
        end
        stg_pkg::REG_RUN_LEN: begin
          fcnt_nxt = cfg_wdata[FCW-1:0];
        end
        default: ;
      endcase
    end else if (red_r) begin
      if ({1'b0, step_r} >= SR) begin
        step_nxt = PHW'({1'b0, step_r} - SR);
      end else begin
        red_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (acc) begin
      phase_nxt = emit ? ph_wrap[PHW-1:0] : ph_base;
      idx_nxt   = emit ? idx_inc : idx_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RESET;
      red_r   <= 1'b0;
      fcnt_r  <= '0;
      phase_r <= '0;
      idx_r   <= '0;
    end else begin
      step_r  <= step_nxt;
      red_r   <= red_nxt;
      fcnt_r  <= fcnt_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/core/stg_sine_pipe.sv =====
module stg_sine_pipe #(
  parameter int SAMPLE_RATE_HZ = 44100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  stg_pkg::mid_item_t in_item,
  output logic               out_valid,
  output stg_pkg::out_item_t out_item
);

  localparam int PHW   = stg_pkg::PH_W;
  localparam int QW    = stg_pkg::QW;
  localparam int FB    = stg_pkg::FB;
  localparam int NPOLY = stg_pkg::NPOLY;
  localparam int SMW   = stg_pkg::SMP_W;
  localparam int QDW   = PHW + 2;
  localparam int RW    = 34;
  localparam int PRW   = PHW + RW;
  localparam int ESW   = QW + PHW;
  localparam int MW    = QW + SMW;
  localparam int NST   = 7 + NPOLY;

  localparam logic [PHW-1:0] SR    = PHW'(SAMPLE_RATE_HZ);
  localparam logic [QDW-1:0] SR1_Q = QDW'(SAMPLE_RATE_HZ);
  localparam logic [QDW-1:0] SR2_Q = QDW'(2 * SAMPLE_RATE_HZ);
  localparam logic [QDW-1:0] SR3_Q = QDW'(3 * SAMPLE_RATE_HZ);
  localparam logic [ESW-1:0] SR_E  = ESW'(SAMPLE_RATE_HZ);
  // floor(2^(FB+PHW) / SR); estimate is at most one below the true quotient
  localparam logic [RW-1:0]  RECIP = RW'((64'd1 << (FB + PHW)) / 64'(SAMPLE_RATE_HZ));

  typedef struct packed {
    logic [1:0] quad;
    logic       last;
  } meta_t;

  logic [NST-1:0] v_r;
  meta_t          meta_r [NST];

  logic [QDW-1:0] q, q_base, r;
  logic [1:0]     quad;
  logic [PHW-1:0] n;

  logic [PHW-1:0] a_n_r, b_n_r, c_n_r;
  logic [PRW-1:0] b_prod_r;
  logic [QW-1:0]  c_est_r;
  logic [ESW-1:0] c_esr_r, rem;
  logic [QW-1:0]  d_u_r, e_u_r, e_u2_r;
  logic [QW-1:0]  pp_r  [NPOLY];
  logic [QW-1:0]  pu_r  [NPOLY];
  logic [QW-1:0]  pu2_r [NPOLY-1];
  logic [QW-1:0]  k_s_r;
  logic [MW-1:0]  mprod;
  logic [SMW-1:0] mag, sat;
  logic [SMW-1:0] l_smp_r;

  // quadrant fold
  always_comb begin
    q = {in_item.phase, 2'b00};
    if (q >= SR3_Q) begin
      quad   = 2'd3;
      q_base = SR3_Q;
    end else if (q >= SR2_Q) begin
      quad   = 2'd2;
      q_base = SR2_Q;
    end else if (q >= SR1_Q) begin
      quad   = 2'd1;
      q_base = SR1_Q;
    end else begin
      quad   = 2'd0;
      q_base = '0;
    end
    r = q - q_base;
    n = quad[0] ? SR - r[PHW-1:0] : r[PHW-1:0];
  end

  assign rem   = {1'b0, c_n_r, {FB{1'b0}}} - c_esr_r;
  assign mprod = k_s_r * stg_pkg::MAG_MAX;
  assign mag   = mprod[FB+SMW-1:FB];
  assign sat   = (mag > stg_pkg::MAG_MAX) ? stg_pkg::MAG_MAX : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= '{quad: quad, last: in_item.last};
    for (int i = 1; i < NST; i++) begin
      meta_r[i] <= meta_r[i-1];
    end

    a_n_r    <= n;
    b_prod_r <= a_n_r * RECIP;
    b_n_r    <= a_n_r;
    c_est_r  <= b_prod_r[PHW+QW-1:PHW];
    c_esr_r  <= b_prod_r[PHW+QW-1:PHW] * SR;
    c_n_r    <= b_n_r;
    d_u_r    <= (rem >= SR_E) ? c_est_r + 1'b1 : c_est_r;
    e_u2_r   <= stg_pkg::qmul(d_u_r, d_u_r);
    e_u_r    <= d_u_r;

    pp_r[0]  <= stg_pkg::POLY_COEF[0] - stg_pkg::qmul(e_u2_r, stg_pkg::C11);
    pu_r[0]  <= e_u_r;
    pu2_r[0] <= e_u2_r;
    for (int k = 1; k < NPOLY; k++) begin
      pp_r[k] <= stg_pkg::POLY_COEF[k] - stg_pkg::qmul(pu2_r[k-1], pp_r[k-1]);
      pu_r[k] <= pu_r[k-1];
    end
    for (int k = 1; k < NPOLY - 1; k++) begin
      pu2_r[k] <= pu2_r[k-1];
    end

    k_s_r   <= stg_pkg::qmul(pu_r[NPOLY-1], pp_r[NPOLY-1]);
    l_smp_r <= meta_r[NST-2].quad[1] ? SMW'(0) - sat : sat;
  end

  assign out_valid       = v_r[NST-1];
  assign out_item.sample = l_smp_r;
  assign out_item.last   = meta_r[NST-1].last;

endmodule

// ===== rtl/core/sine_tone_generator.sv =====
// Sine tone generator: one stereo sample per accepted tick while the run lasts.
// Throughput: one tick per clock while full is low; the sine path is a 12-stage pipeline.
// After a tone_freq write, full stays high while the step is reduced modulo the sample rate.
// Reset (synchronous, rst_n low): queues empty, phase and frame index zero,
// tone_freq 440, run length 0.
module sine_tone_generator #(
  parameter int SAMPLE_RATE_HZ = 44100,
  parameter int INDEX_BITS     = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [stg_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_restart,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [stg_pkg::SMP_W-1:0] out_left_sample,
  output logic signed [stg_pkg::SMP_W-1:0] out_right_sample,
  output logic                             out_last_frame
);

  localparam int MID_AW = 2;
  localparam int OUT_AW = 4;
  localparam int MID_W  = $bits(stg_pkg::mid_item_t);
  localparam int OUT_W  = $bits(stg_pkg::out_item_t);

  logic               q_full, q_push, mid_empty, issue;
  stg_pkg::mid_item_t q_item, mid_item;
  logic [MID_W-1:0]   mid_rdata;
  logic               pipe_valid, out_full;
  stg_pkg::out_item_t pipe_item, o_item;
  logic [OUT_W-1:0]   out_rdata;
  logic [OUT_AW:0]    pend_r, pend_nxt;
  logic               pop_xfer;

  stg_front #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ),
    .INDEX_BITS    (INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .in_restart(in_restart),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  stg_fifo #(
    .WIDTH(MID_W),
    .AW   (MID_AW)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_item),
    .full (q_full),
    .pop  (issue),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  assign mid_item = mid_rdata;

  // credits: items in the pipe plus those held in the output queue
  assign issue    = ~mid_empty & ~pend_r[OUT_AW];
  assign pop_xfer = pop & ~empty;

  always_comb begin
    pend_nxt = pend_r;
    if (issue && !pop_xfer) begin
      pend_nxt = pend_r + 1'b1;
    end else if (pop_xfer && !issue) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  stg_sine_pipe #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (issue),
    .in_item  (mid_item),
    .out_valid(pipe_valid),
    .out_item (pipe_item)
  );

  stg_fifo #(
    .WIDTH(OUT_W),
    .AW   (OUT_AW)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (pipe_valid),
    .wdata(pipe_item),
    .full (out_full),
    .pop  (pop_xfer),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign o_item           = out_rdata;
  assign out_left_sample  = o_item.sample;
  assign out_right_sample = o_item.sample;
  assign out_last_frame   = o_item.last | (out_full & 1'b0);

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int          LIMIT_CYCLES = 500000;
  localparam int          SETTLE       = 20;
  localparam int          MODE_TICKS   = 330;
  localparam logic [63:0] RATE         = 64'd44100;
  localparam logic [63:0] Q30          = 64'd1 << 30;
  localparam logic [63:0] DEC          = 64'd10000000000;
  localparam logic [63:0] SIN_K1       = (64'd15707963268 * Q30) / DEC;
  localparam logic [63:0] SIN_K3       = (64'd6459640975 * Q30) / DEC;
  localparam logic [63:0] SIN_K5       = (64'd796926262 * Q30) / DEC;
  localparam logic [63:0] SIN_K7       = (64'd46817541 * Q30) / DEC;
  localparam logic [63:0] SIN_K9       = (64'd1604411 * Q30) / DEC;
  localparam logic [63:0] SIN_K11      = (64'd35988 * Q30) / DEC;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_we     = 1'b0;
  logic [0:0]                       cfg_index  = stg_pkg::REG_TONE_FREQ;
  logic [stg_pkg::CFG_W-1:0]        cfg_wdata  = '0;
  logic                             push       = 1'b0;
  logic                             in_restart = 1'b0;
  logic                             pop        = 1'b0;
  logic                             full;
  logic                             empty;
  logic signed [stg_pkg::SMP_W-1:0] out_left_sample;
  logic signed [stg_pkg::SMP_W-1:0] out_right_sample;
  logic                             out_last_frame;

  // oscillator model state
  int unsigned tone_reg   = stg_pkg::TONE_RESET;
  int unsigned count_reg  = 0;
  int unsigned phase_q    = 0;
  int unsigned index_q    = 0;

  stg_pkg::out_item_t expected_frames[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int errors         = 0;
  int ticks_sent     = 0;
  int restarts_sent  = 0;
  int frames_due     = 0;
  int frames_checked = 0;
  int cfg_writes     = 0;
  int full_cycles    = 0;

  sine_tone_generator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_restart       (in_restart),
    .empty            (empty),
    .pop              (pop),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last_frame   (out_last_frame)
  );

  always #5 clk = ~clk;

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [stg_pkg::SMP_W-1:0] sine_of_phase(input int unsigned ph);
    logic [63:0] q, quad, r, n, u, u2, p, s, mag;
    q    = 64'(ph) << 2;
    quad = (q / RATE) & 64'd3;
    r    = q % RATE;
    n    = quad[0] ? (RATE - r) : r;
    u    = (n << 30) / RATE;
    u2   = q30_mul(u, u);
    p    = SIN_K9 - q30_mul(u2, SIN_K11);
    p    = SIN_K7 - q30_mul(u2, p);
    p    = SIN_K5 - q30_mul(u2, p);
    p    = SIN_K3 - q30_mul(u2, p);
    p    = SIN_K1 - q30_mul(u2, p);
    s    = q30_mul(u, p);
    mag  = (64'd32767 * s) >> 30;
    if (mag > 64'd32767) mag = 64'd32767;
    if (quad >= 64'd2) mag = 64'd0 - mag;
    return mag[stg_pkg::SMP_W-1:0];
  endfunction

  function automatic void advance_oscillator(input logic rs);
    stg_pkg::out_item_t item;
    if (rs) begin
      phase_q = 0;
      index_q = 0;
    end
    if (index_q >= count_reg) return;
    item.sample = sine_of_phase(phase_q);
    item.last   = (index_q + 1 == count_reg);
    expected_frames.push_back(item);
    frames_due++;
    index_q = (index_q + 1) & 32'hFF_FFFF;
    phase_q = (phase_q + tone_reg % 44100) % 44100;
  endfunction

  task automatic send_tick(input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_restart <= rs;
    do begin
      @(posedge clk);
      if (full) full_cycles++;
    end while (full);
    ticks_sent++;
    if (rs) restarts_sent++;
    advance_oscillator(rs);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input stg_pkg::cfg_reg_t idx,
                           input logic [stg_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      stg_pkg::REG_TONE_FREQ: tone_reg  = 32'(val[stg_pkg::PH_W-1:0]);
      stg_pkg::REG_RUN_LEN:   count_reg = 32'(val);
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  initial begin : receiver
    stg_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (expected_frames.size() == 0) begin
          $error("frame with nothing expected: left_sample %0d", out_left_sample);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (out_left_sample !== want.sample) begin
            $error("left_sample: expected %0d, got %0d", want.sample, out_left_sample);
            errors++;
          end
          if (out_right_sample !== want.sample) begin
            $error("right_sample: expected %0d, got %0d", want.sample, out_right_sample);
            errors++;
          end
          if (out_last_frame !== want.last) begin
            $error("last_frame: expected %0b, got %0b", want.last, out_last_frame);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run length is zero out of reset: ticks give nothing
  task automatic test_idle_after_reset();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
  endtask

  // reset tone, short runs, end of run, restart after the end and mid-run
  task automatic test_directed_runs();
    write_cfg(stg_pkg::REG_RUN_LEN, 24'd4);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    drain();
    write_cfg(stg_pkg::REG_TONE_FREQ, 24'd11025);
    write_cfg(stg_pkg::REG_RUN_LEN, 24'd5);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    write_cfg(stg_pkg::REG_TONE_FREQ, 24'hFFFF);
    write_cfg(stg_pkg::REG_RUN_LEN, 24'hFF_FFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();
    write_cfg(stg_pkg::REG_TONE_FREQ, 24'd0);
    write_cfg(stg_pkg::REG_RUN_LEN, 24'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
  endtask

  function automatic logic [stg_pkg::CFG_W-1:0] pick_run_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 24'hFF_FFFF;
      2:       return stg_pkg::CFG_W'($urandom_range(24'hFF_FFFF));
      3, 4:    return stg_pkg::CFG_W'($urandom_range(2000, 200));
      default: return stg_pkg::CFG_W'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic logic [stg_pkg::CFG_W-1:0] pick_tone();
    case ($urandom_range(7))
      0:       return 24'd0;
      1:       return 24'hFFFF;
      2:       return 24'd44100;
      3:       return 24'd44099;
      default: return stg_pkg::CFG_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic test_random_runs();
    int idle_modes [4]  = '{0, 83, 0, 21};
    int stall_modes [4] = '{0, 0, 83, 21};
    int start, seg;
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = idle_modes[m];
      recv_stall_pct = stall_modes[m];
      start          = ticks_sent;
      while (ticks_sent - start < MODE_TICKS) begin
        write_cfg(stg_pkg::REG_TONE_FREQ, pick_tone());
        write_cfg(stg_pkg::REG_RUN_LEN, pick_run_len());
        seg = $urandom_range(90, 30);
        send_tick(1'b1);
        repeat (seg) send_tick($urandom_range(19) == 0);
        drain();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while ticks keep coming, so the block must stall its input
  task automatic test_backpressure();
    write_cfg(stg_pkg::REG_TONE_FREQ, stg_pkg::CFG_W'($urandom_range(16'hFFFF)));
    write_cfg(stg_pkg::REG_RUN_LEN, 24'hFF_FFFF);
    hold_left = 400;
    send_tick(1'b1);
    repeat (150) send_tick(1'b0);
    drain();
  endtask

  initial begin : main
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_after_reset();
    test_directed_runs();
    test_backpressure();
    test_random_runs();
    $display("Sent %0d ticks (%0d restarts) over %0d register writes; %0d frames checked.",
             ticks_sent, restarts_sent, cfg_writes, frames_checked);
    $display("Input held off by full for %0d cycles; idle and stall mixes all exercised.",
             full_cycles);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/stg_pkg.sv
rtl/core/stg_fifo.sv
rtl/core/stg_front.sv
rtl/core/stg_sine_pipe.sv
rtl/core/sine_tone_generator.sv
tb/tb.sv
